FILE: src/mf5_pkg.sv
// Shared constants, codes and types of the 5x5 RGB median filter.
// No dependencies; every other file of the block but mf5_ram refers to it by scoped names.
`default_nettype none

package mf5_pkg;

    // pixel and channel geometry
    localparam int CHAN_BITS    = 8;
    localparam int PIX_BITS     = 3 * CHAN_BITS;
    localparam int MAX_WIDTH    = 1024;
    localparam int COL_BITS     = $clog2(MAX_WIDTH);
    localparam int HEIGHT_LIMIT = 1024;
    localparam int DIM_BITS     = 11;

    // window geometry
    localparam int WIN       = 5;
    localparam int HALF      = WIN / 2;
    localparam int WIN_COUNT = WIN * WIN;
    localparam int MED_RANK  = WIN_COUNT / 2;
    localparam int RANK_BITS = $clog2(WIN_COUNT);
    localparam int PART_BITS = $clog2(WIN + 1);
    localparam int LINE_BITS = (WIN - 1) * PIX_BITS;
    localparam int LEAD_BITS = DIM_BITS + 1;
    localparam int MED_LAT   = 4;

    // queues
    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_PTR   = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT   = CMDQ_PTR + 1;
    localparam int RESQ_DEPTH = 16;
    localparam int RESQ_PTR   = $clog2(RESQ_DEPTH);
    localparam int RESQ_CNT   = RESQ_PTR + 1;

    // configuration register map
    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT = 2'd1;
    localparam logic [DIM_BITS-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [DIM_BITS-1:0] HEIGHT_RESET = 11'd480;

    // input commands
    localparam logic CMD_PUSH  = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    typedef logic [PIX_BITS-1:0] t_pix;

    // one classified step, front to back
    typedef struct packed {
        logic [COL_BITS-1:0] col;
        t_pix                pix;
        logic                emit;
        logic [WIN-1:0]      row_ok;
        logic [WIN-1:0]      col_ok;
        logic                done;
    } t_cmd;

    // one result word
    typedef struct packed {
        logic [CHAN_BITS-1:0] red;
        logic [CHAN_BITS-1:0] green;
        logic [CHAN_BITS-1:0] blue;
        logic                 done;
    } t_res;

endpackage

`default_nettype wire

FILE: src/mf5_pix_if.sv
// Pixel input channel: valid/ready handshake with command and RGB payload.
// Depends on mf5_pkg.
`default_nettype none

interface mf5_pix_if;
    logic                          valid;
    logic                          ready;
    logic                          command;
    logic [mf5_pkg::CHAN_BITS-1:0] in_blue;
    logic [mf5_pkg::CHAN_BITS-1:0] in_green;
    logic [mf5_pkg::CHAN_BITS-1:0] in_red;

    modport source (output valid, command, in_blue, in_green, in_red, input ready);
    modport sink   (input valid, command, in_blue, in_green, in_red, output ready);
endinterface

`default_nettype wire

FILE: src/mf5_res_if.sv
// Result output channel: valid/ready handshake with median RGB and frame flag.
// Depends on mf5_pkg.
`default_nettype none

interface mf5_res_if;
    logic                          valid;
    logic                          ready;
    logic [mf5_pkg::CHAN_BITS-1:0] out_blue;
    logic [mf5_pkg::CHAN_BITS-1:0] out_green;
    logic [mf5_pkg::CHAN_BITS-1:0] out_red;
    logic                          frame_done;

    modport source (output valid, out_blue, out_green, out_red, frame_done, input ready);
    modport sink   (input valid, out_blue, out_green, out_red, frame_done, output ready);
endinterface

`default_nettype wire

FILE: src/median_filter_5x5_rgb_core.sv
// Streaming 5x5 RGB median filter: one item per clock while the queues have room, no iteration.
// An item's result word follows the item that completes its window through the
// command queue, line store read, window, four median stages and result queue.
// Results trail the pixel stream by two rows plus two pixels; drain words flush them.
// Synchronous active-low reset clears counters and queues, width 640, height 480;
// the line store is not cleared, rows above a frame's top are substituted instead.
`default_nettype none

module median_filter_5x5_rgb_core (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [mf5_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  wire logic [mf5_pkg::DIM_BITS-1:0]     i_cfg_data,
    mf5_pix_if.sink                               i_pix,
    mf5_res_if.source                             o_res
);

    mf5_pkg::t_cmd cmd;
    logic          cmd_valid;
    logic          cmd_pop;

    mf5_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_pix       (i_pix),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid),
        .i_cmd_pop   (cmd_pop)
    );

    mf5_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_cmd_pop   (cmd_pop),
        .o_res       (o_res)
    );

`ifndef SYNTHESIS
    // the back end only takes words the queue holds
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_pop |-> cmd_valid)
        else $error("command popped from empty queue");

    // the frame end flag rides only on a result-producing step
    a_done_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd_valid && cmd.done) |-> cmd.emit)
        else $error("frame end without a result");

    // the centre of a result window always lies inside the image
    a_centre_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd_valid && cmd.emit) |-> (cmd.row_ok[mf5_pkg::HALF] && cmd.col_ok[mf5_pkg::HALF]))
        else $error("result centre outside image");

    // nothing is offered right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res.valid)
        else $error("result offered after reset");
`endif

endmodule

`default_nettype wire

FILE: src/mf5_ram.sv
// Generic single-write, single-read RAM with registered read (old data on collision).
// No dependencies.
`default_nettype none

module mf5_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: src/mf5_front.sv
// Front end: config registers, frame position counters, step classification
// and the short command queue to the back end. Depends on mf5_pkg, mf5_pix_if.
`default_nettype none

module mf5_front (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [mf5_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  wire logic [mf5_pkg::DIM_BITS-1:0]       i_cfg_data,
    mf5_pix_if.sink                                 i_pix,
    output mf5_pkg::t_cmd                           o_cmd,
    output logic                                    o_cmd_valid,
    input  wire logic                               i_cmd_pop
);

    logic [mf5_pkg::DIM_BITS-1:0]  r_width, r_height;
    logic [mf5_pkg::DIM_BITS-1:0]  w_eff, h_eff;
    logic [mf5_pkg::DIM_BITS-1:0]  r_in_row, r_in_col, r_out_row, r_out_col;
    logic [mf5_pkg::LEAD_BITS-1:0] r_lead, lag;
    logic [mf5_pkg::DIM_BITS:0]    rr, cc;
    logic                          accept, in_done, ignore, step, emit, done;
    mf5_pkg::t_cmd                 n_cmd;

    mf5_pkg::t_cmd                 r_q [mf5_pkg::CMDQ_DEPTH];
    logic [mf5_pkg::CMDQ_PTR-1:0]  r_wr, r_rd;
    logic [mf5_pkg::CMDQ_CNT-1:0]  r_count;

    // effective image size: zero reads as one, oversize saturates
    always_comb begin
        if (r_width == '0) begin
            w_eff = mf5_pkg::DIM_BITS'(1);
        end else if (r_width > mf5_pkg::DIM_BITS'(mf5_pkg::MAX_WIDTH)) begin
            w_eff = mf5_pkg::DIM_BITS'(mf5_pkg::MAX_WIDTH);
        end else begin
            w_eff = r_width;
        end
        if (r_height == '0) begin
            h_eff = mf5_pkg::DIM_BITS'(1);
        end else if (r_height > mf5_pkg::DIM_BITS'(mf5_pkg::HEIGHT_LIMIT)) begin
            h_eff = mf5_pkg::DIM_BITS'(mf5_pkg::HEIGHT_LIMIT);
        end else begin
            h_eff = r_height;
        end
    end

    // results trail the input by half a window of rows and columns
    assign lag = mf5_pkg::LEAD_BITS'(w_eff) * mf5_pkg::LEAD_BITS'(mf5_pkg::HALF)
               + mf5_pkg::LEAD_BITS'(mf5_pkg::HALF);

    // step classification
    assign i_pix.ready = (r_count != mf5_pkg::CMDQ_CNT'(mf5_pkg::CMDQ_DEPTH));
    assign accept      = i_pix.valid && i_pix.ready;
    assign in_done     = (r_in_row >= h_eff);
    assign ignore      = (i_pix.command == mf5_pkg::CMD_DRAIN) && !in_done;
    assign step        = accept && !ignore;
    assign emit        = (r_lead == lag);
    assign done        = emit && (r_out_row == h_eff - mf5_pkg::DIM_BITS'(1))
                              && (r_out_col == w_eff - mf5_pkg::DIM_BITS'(1));

    // command word with the border masks of the result position
    always_comb begin
        n_cmd.col  = r_in_col[mf5_pkg::COL_BITS-1:0];
        n_cmd.pix  = {i_pix.in_red, i_pix.in_green, i_pix.in_blue};
        n_cmd.emit = emit;
        n_cmd.done = done;
        for (int k = 0; k < mf5_pkg::WIN; k++) begin
            rr = {1'b0, r_out_row} + (mf5_pkg::DIM_BITS + 1)'(k);
            cc = {1'b0, r_out_col} + (mf5_pkg::DIM_BITS + 1)'(k);
            n_cmd.row_ok[k] = (rr >= (mf5_pkg::DIM_BITS + 1)'(mf5_pkg::HALF))
                && (rr < {1'b0, h_eff} + (mf5_pkg::DIM_BITS + 1)'(mf5_pkg::HALF));
            n_cmd.col_ok[k] = (cc >= (mf5_pkg::DIM_BITS + 1)'(mf5_pkg::HALF))
                && (cc < {1'b0, w_eff} + (mf5_pkg::DIM_BITS + 1)'(mf5_pkg::HALF));
        end
    end

    // registers and frame counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= mf5_pkg::WIDTH_RESET;
            r_height  <= mf5_pkg::HEIGHT_RESET;
            r_in_row  <= '0;
            r_in_col  <= '0;
            r_out_row <= '0;
            r_out_col <= '0;
            r_lead    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mf5_pkg::REG_WIDTH: begin
                    r_width   <= i_cfg_data;
                    r_in_row  <= '0;
                    r_in_col  <= '0;
                    r_out_row <= '0;
                    r_out_col <= '0;
                    r_lead    <= '0;
                end
                mf5_pkg::REG_HEIGHT: begin
                    r_height  <= i_cfg_data;
                    r_in_row  <= '0;
                    r_in_col  <= '0;
                    r_out_row <= '0;
                    r_out_col <= '0;
                    r_lead    <= '0;
                end
                default: begin
                end
            endcase
        end else if (step) begin
            if (done) begin
                r_in_row  <= '0;
                r_in_col  <= '0;
                r_out_row <= '0;
                r_out_col <= '0;
                r_lead    <= '0;
            end else begin
                if (r_in_col == w_eff - mf5_pkg::DIM_BITS'(1)) begin
                    r_in_col <= '0;
                    r_in_row <= r_in_row + mf5_pkg::DIM_BITS'(1);
                end else begin
                    r_in_col <= r_in_col + mf5_pkg::DIM_BITS'(1);
                end
                if (emit) begin
                    if (r_out_col == w_eff - mf5_pkg::DIM_BITS'(1)) begin
                        r_out_col <= '0;
                        r_out_row <= r_out_row + mf5_pkg::DIM_BITS'(1);
                    end else begin
                        r_out_col <= r_out_col + mf5_pkg::DIM_BITS'(1);
                    end
                end else begin
                    r_lead <= r_lead + mf5_pkg::LEAD_BITS'(1);
                end
            end
        end
    end

    // command queue control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (step) begin
                r_wr <= r_wr + mf5_pkg::CMDQ_PTR'(1);
            end
            if (i_cmd_pop) begin
                r_rd <= r_rd + mf5_pkg::CMDQ_PTR'(1);
            end
            r_count <= r_count + mf5_pkg::CMDQ_CNT'(step) - mf5_pkg::CMDQ_CNT'(i_cmd_pop);
        end
    end

    // command queue storage
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_q[r_wr] <= n_cmd;
        end
    end

    assign o_cmd       = r_q[r_rd];
    assign o_cmd_valid = (r_count != '0);

endmodule

`default_nettype wire

FILE: src/mf5_median.sv
// Pipelined rank-select median of one channel over the 25 window values.
// Four register stages: compare matrix, partial counts, ranks, select. Depends on mf5_pkg.
`default_nettype none

module mf5_median (
    input  wire logic                                                     i_clk,
    input  wire logic [mf5_pkg::WIN_COUNT-1:0][mf5_pkg::CHAN_BITS-1:0]    i_vals,
    output logic      [mf5_pkg::CHAN_BITS-1:0]                            o_med
);

    logic [mf5_pkg::WIN_COUNT-1:0][mf5_pkg::CHAN_BITS-1:0] r_v1, r_v2, r_v3;
    logic [mf5_pkg::WIN_COUNT-1:0][mf5_pkg::WIN_COUNT-1:0] r_lt, n_lt;
    logic [mf5_pkg::WIN_COUNT-1:0][mf5_pkg::WIN-1:0][mf5_pkg::PART_BITS-1:0] r_part, n_part;
    logic [mf5_pkg::WIN_COUNT-1:0][mf5_pkg::RANK_BITS-1:0] r_rank, n_rank;
    logic [mf5_pkg::CHAN_BITS-1:0]                         r_med, n_med;

    // element j sorts below element i; ties broken by position
    always_comb begin
        for (int i = 0; i < mf5_pkg::WIN_COUNT; i++) begin
            for (int j = 0; j < mf5_pkg::WIN_COUNT; j++) begin
                if (j < i) begin
                    n_lt[i][j] = (i_vals[j] <= i_vals[i]);
                end else if (j > i) begin
                    n_lt[i][j] = (i_vals[j] < i_vals[i]);
                end else begin
                    n_lt[i][j] = 1'b0;
                end
            end
        end
    end

    // partial counts over groups of one window row
    always_comb begin
        for (int i = 0; i < mf5_pkg::WIN_COUNT; i++) begin
            for (int g = 0; g < mf5_pkg::WIN; g++) begin
                n_part[i][g] = '0;
                for (int e = 0; e < mf5_pkg::WIN; e++) begin
                    n_part[i][g] = n_part[i][g]
                        + mf5_pkg::PART_BITS'(r_lt[i][g * mf5_pkg::WIN + e]);
                end
            end
        end
    end

    // full rank of each element
    always_comb begin
        for (int i = 0; i < mf5_pkg::WIN_COUNT; i++) begin
            n_rank[i] = '0;
            for (int g = 0; g < mf5_pkg::WIN; g++) begin
                n_rank[i] = n_rank[i] + mf5_pkg::RANK_BITS'(r_part[i][g]);
            end
        end
    end

    // exactly one element holds the middle rank
    always_comb begin
        n_med = '0;
        for (int i = 0; i < mf5_pkg::WIN_COUNT; i++) begin
            if (r_rank[i] == mf5_pkg::RANK_BITS'(mf5_pkg::MED_RANK)) begin
                n_med = n_med | r_v3[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_v1   <= i_vals;
        r_lt   <= n_lt;
        r_v2   <= r_v1;
        r_part <= n_part;
        r_v3   <= r_v2;
        r_rank <= n_rank;
        r_med  <= n_med;
    end

    assign o_med = r_med;

endmodule

`default_nettype wire

FILE: src/mf5_back.sv
// Back end: line store RAM, 5x5 window, border substitution, three channel
// medians and the result queue. Depends on mf5_pkg, mf5_res_if, mf5_ram, mf5_median.
`default_nettype none

module mf5_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire mf5_pkg::t_cmd i_cmd,
    input  wire logic          i_cmd_valid,
    output logic               o_cmd_pop,
    mf5_res_if.source          o_res
);

    logic [mf5_pkg::RESQ_CNT-1:0]  r_used;
    logic                          r_s1_valid;
    mf5_pkg::t_cmd                 r_s1;
    logic [mf5_pkg::LINE_BITS-1:0] ram_rdata, line, wdata;
    logic                          r_fwd_hit;
    logic [mf5_pkg::LINE_BITS-1:0] r_fwd_data;
    mf5_pkg::t_pix                 col_new [mf5_pkg::WIN];
    mf5_pkg::t_pix                 r_win [mf5_pkg::WIN][mf5_pkg::WIN];
    logic                          r_s2_valid;
    logic [mf5_pkg::WIN-1:0]       r_s2_row_ok, r_s2_col_ok;
    logic                          r_s2_done;
    mf5_pkg::t_pix                 sel_pix;
    logic [mf5_pkg::WIN_COUNT-1:0][mf5_pkg::CHAN_BITS-1:0] vb, vg, vr;
    logic [mf5_pkg::CHAN_BITS-1:0] med_b, med_g, med_r;
    logic [mf5_pkg::MED_LAT-1:0]   r_vl, r_dl;

    mf5_pkg::t_res                 r_rq [mf5_pkg::RESQ_DEPTH];
    logic [mf5_pkg::RESQ_PTR-1:0]  r_rwr, r_rrd;
    logic [mf5_pkg::RESQ_CNT-1:0]  r_rcount;
    logic                          res_push, res_pop;

    // take a step only while the result queue has room for everything in flight
    assign o_cmd_pop = i_cmd_valid && (r_used < mf5_pkg::RESQ_CNT'(mf5_pkg::RESQ_DEPTH));

    // line store: four rows above the current column, newest row lowest
    mf5_ram #(
        .WIDTH (mf5_pkg::LINE_BITS),
        .DEPTH (mf5_pkg::MAX_WIDTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1.col),
        .i_wdata (wdata),
        .i_raddr (i_cmd.col),
        .o_rdata (ram_rdata)
    );

    // forward a write to the same column issued in the read cycle
    assign line  = r_fwd_hit ? r_fwd_data : ram_rdata;
    assign wdata = {line[mf5_pkg::LINE_BITS-mf5_pkg::PIX_BITS-1:0], r_s1.pix};

    // new window column, oldest row first
    always_comb begin
        col_new[mf5_pkg::WIN-1] = r_s1.pix;
        for (int j = 0; j < mf5_pkg::WIN - 1; j++) begin
            col_new[j] = line[(mf5_pkg::WIN - 2 - j) * mf5_pkg::PIX_BITS +: mf5_pkg::PIX_BITS];
        end
    end

    // stage 1 and 2 control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd_hit  <= 1'b0;
            r_s2_valid <= 1'b0;
            r_vl       <= '0;
        end else begin
            r_s1_valid <= o_cmd_pop;
            r_fwd_hit  <= o_cmd_pop && r_s1_valid && (i_cmd.col == r_s1.col);
            r_s2_valid <= r_s1_valid && r_s1.emit;
            r_vl       <= {r_vl[mf5_pkg::MED_LAT-2:0], r_s2_valid};
        end
    end

    // stage payloads and window shift
    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_s1 <= i_cmd;
        end
        r_fwd_data <= wdata;
        if (r_s1_valid) begin
            for (int c = 0; c < mf5_pkg::WIN - 1; c++) begin
                r_win[c] <= r_win[c + 1];
            end
            r_win[mf5_pkg::WIN-1] <= col_new;
            r_s2_row_ok <= r_s1.row_ok;
            r_s2_col_ok <= r_s1.col_ok;
            r_s2_done   <= r_s1.done;
        end
        r_dl <= {r_dl[mf5_pkg::MED_LAT-2:0], r_s2_done};
    end

    // positions off the image take the centre pixel
    always_comb begin
        for (int r = 0; r < mf5_pkg::WIN; r++) begin
            for (int c = 0; c < mf5_pkg::WIN; c++) begin
                sel_pix = (r_s2_row_ok[r] && r_s2_col_ok[c]) ? r_win[c][r]
                        : r_win[mf5_pkg::HALF][mf5_pkg::HALF];
                vb[r * mf5_pkg::WIN + c] = sel_pix[mf5_pkg::CHAN_BITS-1:0];
                vg[r * mf5_pkg::WIN + c] = sel_pix[2*mf5_pkg::CHAN_BITS-1:mf5_pkg::CHAN_BITS];
                vr[r * mf5_pkg::WIN + c] = sel_pix[3*mf5_pkg::CHAN_BITS-1:2*mf5_pkg::CHAN_BITS];
            end
        end
    end

    mf5_median u_med_b (.i_clk(i_clk), .i_vals(vb), .o_med(med_b));
    mf5_median u_med_g (.i_clk(i_clk), .i_vals(vg), .o_med(med_g));
    mf5_median u_med_r (.i_clk(i_clk), .i_vals(vr), .o_med(med_r));

    // result queue
    assign res_push = r_vl[mf5_pkg::MED_LAT-1];
    assign res_pop  = o_res.valid && o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rwr    <= '0;
            r_rrd    <= '0;
            r_rcount <= '0;
            r_used   <= '0;
        end else begin
            if (res_push) begin
                r_rwr <= r_rwr + mf5_pkg::RESQ_PTR'(1);
            end
            if (res_pop) begin
                r_rrd <= r_rrd + mf5_pkg::RESQ_PTR'(1);
            end
            r_rcount <= r_rcount + mf5_pkg::RESQ_CNT'(res_push) - mf5_pkg::RESQ_CNT'(res_pop);
            r_used   <= r_used + mf5_pkg::RESQ_CNT'(o_cmd_pop && i_cmd.emit)
                      - mf5_pkg::RESQ_CNT'(res_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_push) begin
            r_rq[r_rwr] <= '{red: med_r, green: med_g, blue: med_b,
                             done: r_dl[mf5_pkg::MED_LAT-1]};
        end
    end

    assign o_res.valid      = (r_rcount != '0);
    assign o_res.out_blue   = r_rq[r_rrd].blue;
    assign o_res.out_green  = r_rq[r_rrd].green;
    assign o_res.out_red    = r_rq[r_rrd].red;
    assign o_res.frame_done = r_rq[r_rrd].done;

endmodule

`default_nettype wire
